@@ hw/rtl/aer_pkg.sv @@
// Package for the audio effect rack: effect codes, sequencer states and widths.
// Used by audio_effect_rack; depends on nothing.
package aer_pkg;
	localparam int SampleBits = 12;
	localparam int OutBits = 23;
	localparam int AccBits = 40;
	localparam int MulBits = 24;

	typedef enum logic [3:0] {
		FX_NONE = 4'd0, FX_LOWPASS = 4'd1, FX_HIGHPASS = 4'd2, FX_BANDPASS = 4'd3,
		FX_CRUSH = 4'd4, FX_DECIMATE = 4'd5, FX_FOLD = 4'd6, FX_GATE = 4'd10,
		FX_MUTE = 4'd12
	} effect_t;

	localparam logic REG_SELECT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_Q, ST_C, ST_G1, ST_G2, ST_G3, ST_HP, ST_BAND, ST_LOW, ST_FOLD,
		ST_GATE, ST_DONE
	} state_t;
endpackage

@@ hw/rtl/audio_effect_rack.sv @@
// Audio effect rack top level: sequencer around one shared multiplier.
// Depends on aer_pkg.
//
// Samples are requested on sample_in with in_valid/in_ready; each result
// appears on sample_out with out_valid/out_ready. Configuration requests
// arrive on cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 selects
// the effect and index 1 sets the depth. The port is always ready.
// A filter sample steps through ST_Q, ST_C, ST_G1, ST_G2, ST_G3, ST_HP,
// ST_BAND and ST_LOW, since the coefficient taper and filter use the one
// multiplier in turn; the wavefolder repeats ST_FOLD, the gate passes
// through ST_GATE and all others through ST_DONE. The input is taken
// again once the result register is empty or being emptied, so a new
// sample is taken only when the last is finished and the receiver keeps up.
// When the receiver stalls the result is held in the output register and
// no further sample is requested. Reset returns the sequencer to idle and
// clears out_valid, the configuration and the filter, decimator and gate state, but not the result register.
module audio_effect_rack (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [aer_pkg::SampleBits-1:0] sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [aer_pkg::OutBits-1:0]  sample_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [11:0]                         cfg_data
);
	logic [3:0] sel_q;
	logic [11:0] depth_q;
	logic signed [21:0] band_q, low_q;
	logic signed [aer_pkg::SampleBits-1:0] held_q, x_q;
	logic [5:0] hcnt_q;
	logic [15:0] phase_q;
	logic signed [aer_pkg::AccBits-1:0] a_q, b_q, hp_q, t_q;
	logic signed [aer_pkg::AccBits-1:0] r_q, qv_q, cv_q;
	logic [1:0] fold_q;
	logic signed [aer_pkg::OutBits-1:0] res_q;
	logic ov_q;
	aer_pkg::state_t state_q, state_d;

	logic signed [aer_pkg::MulBits-1:0] mul_a, mul_b;
	logic signed [2*aer_pkg::MulBits-1:0] prod_w;
	logic signed [aer_pkg::AccBits-1:0] prod;
	logic signed [aer_pkg::AccBits-1:0] g_c, band_n, low_n, y_c;
	logic [15:0] rate, half, ph_n, hmg;
	logic signed [aer_pkg::AccBits-1:0] gain;
	logic sel_write;
	logic [aer_pkg::AccBits-1:0] cmask;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == aer_pkg::ST_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign sample_out = res_q;
	assign sel_write = cfg_valid && (cfg_index == aer_pkg::REG_SELECT)
		&& (cfg_data[3:0] != sel_q);

	assign mul_a = a_q[aer_pkg::MulBits-1:0];
	assign mul_b = b_q[aer_pkg::MulBits-1:0];
	assign prod_w = mul_a * mul_b;
	assign prod = prod_w[aer_pkg::AccBits-1:0];

	function automatic logic signed [aer_pkg::AccBits-1:0] clampst(
			input logic signed [aer_pkg::AccBits-1:0] v);
		if (v > (40'sd1 <<< 20)) return 40'sd1 <<< 20;
		if (v < -(40'sd1 <<< 20)) return -(40'sd1 <<< 20);
		return v;
	endfunction

	always_comb begin
		g_c = 40'sd400 + (t_q >>> 15);
		if (g_c > 40'sd20000) g_c = 40'sd20000;
		if (g_c < 40'sd200) g_c = 40'sd200;
		band_n = band_q + (prod >>> 15);
		low_n = low_q + (prod >>> 15);
		rate = 16'd64 + 16'((16'd4095 - {4'd0, depth_q}) * 16'd12);
		ph_n = phase_q + 16'd1;
		if (ph_n >= rate) ph_n = '0;
		half = rate >> 1;
		hmg = half - ph_n;
		if (ph_n < 16'd32) gain = 40'(ph_n) * 8;
		else if (hmg < 16'd32) gain = 40'(hmg) * 8;
		else gain = 40'sd256;
		if (gain > 40'sd256) gain = 40'sd256;
		cmask = ~((40'd1 << (4'd1 + 4'(({3'd0, depth_q} * 15'd8) >> 12))) - 40'd1);
		y_c = 40'(x_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			aer_pkg::ST_IDLE: if (in_valid && in_ready) begin
				case (sel_q)
					aer_pkg::FX_LOWPASS, aer_pkg::FX_HIGHPASS,
					aer_pkg::FX_BANDPASS: state_d = aer_pkg::ST_Q;
					aer_pkg::FX_FOLD: state_d = aer_pkg::ST_FOLD;
					aer_pkg::FX_GATE: state_d = aer_pkg::ST_GATE;
					default: state_d = aer_pkg::ST_DONE;
				endcase
			end
			aer_pkg::ST_Q: state_d = aer_pkg::ST_C;
			aer_pkg::ST_C: state_d = aer_pkg::ST_G1;
			aer_pkg::ST_G1: state_d = aer_pkg::ST_G2;
			aer_pkg::ST_G2: state_d = aer_pkg::ST_G3;
			aer_pkg::ST_G3: state_d = aer_pkg::ST_HP;
			aer_pkg::ST_HP: state_d = aer_pkg::ST_BAND;
			aer_pkg::ST_BAND: state_d = aer_pkg::ST_LOW;
			aer_pkg::ST_LOW: state_d = aer_pkg::ST_IDLE;
			aer_pkg::ST_FOLD: if (fold_q == 2'd3) state_d = aer_pkg::ST_IDLE;
			aer_pkg::ST_GATE: state_d = aer_pkg::ST_IDLE;
			aer_pkg::ST_DONE: state_d = aer_pkg::ST_IDLE;
			default: state_d = aer_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aer_pkg::ST_IDLE;
			ov_q <= 1'b0;
			sel_q <= '0; depth_q <= '0; band_q <= '0; low_q <= '0;
			held_q <= '0; hcnt_q <= '0; phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (cfg_valid && cfg_index != aer_pkg::REG_SELECT) depth_q <= cfg_data;
			if (sel_write) begin
				sel_q <= cfg_data[3:0];
				band_q <= '0; low_q <= '0; held_q <= '0; hcnt_q <= '0;
			end
			case (state_q)
				aer_pkg::ST_IDLE: if (in_valid && in_ready) begin
					x_q <= sample_in;
					r_q <= 40'({depth_q, 3'd0});
					if (sel_q == aer_pkg::FX_FOLD) begin
						a_q <= 40'(sample_in);
						b_q <= 40'sd256 + ((40'(depth_q) * 40'sd1792) >>> 12);
						fold_q <= '0;
					end else if (sel_q == aer_pkg::FX_GATE) begin
						a_q <= 40'(sample_in);
						b_q <= gain;
						phase_q <= ph_n;
					end else begin
						a_q <= 40'({depth_q, 3'd0});
						b_q <= 40'({depth_q, 3'd0});
					end
				end
				aer_pkg::ST_Q: begin
					qv_q <= prod >>> 15;
					a_q <= prod >>> 15;
				end
				aer_pkg::ST_C: begin
					cv_q <= prod >>> 15;
					a_q <= r_q; b_q <= 40'sd3000;
				end
				aer_pkg::ST_G1: begin
					t_q <= prod; a_q <= qv_q; b_q <= 40'sd8000;
				end
				aer_pkg::ST_G2: begin
					t_q <= t_q + prod; a_q <= cv_q; b_q <= 40'sd15000;
				end
				aer_pkg::ST_G3: begin
					t_q <= t_q + prod; a_q <= 40'(band_q); b_q <= 40'sd14000;
				end
				aer_pkg::ST_HP: begin
					hp_q <= y_c - (prod >>> 15) - 40'(low_q);
					a_q <= g_c;
					b_q <= y_c - (prod >>> 15) - 40'(low_q);
					t_q <= g_c;
				end
				aer_pkg::ST_BAND: begin
					band_q <= 22'(clampst(band_n));
					a_q <= t_q; b_q <= band_n;
				end
				aer_pkg::ST_LOW: begin
					low_q <= 22'(clampst(low_n));
					if (sel_q == aer_pkg::FX_LOWPASS) res_q <= 23'(low_n);
					else if (sel_q == aer_pkg::FX_HIGHPASS) res_q <= 23'(hp_q);
					else res_q <= 23'(40'(band_q) >>> 2);
					ov_q <= 1'b1;
				end
				aer_pkg::ST_FOLD: begin
					if (fold_q == 2'd0) t_q <= prod >>> 8;
					else if (t_q > 40'sd2047) t_q <= 40'sd4094 - t_q;
					else if (t_q < -40'sd2047) t_q <= -40'sd4094 - t_q;
					fold_q <= fold_q + 2'd1;
					if (fold_q == 2'd3) begin
						if (t_q > 40'sd2047) res_q <= 23'(40'sd4094 - t_q);
						else if (t_q < -40'sd2047) res_q <= 23'(-40'sd4094 - t_q);
						else res_q <= 23'(t_q);
						ov_q <= 1'b1;
					end
				end
				aer_pkg::ST_GATE: begin
					res_q <= (phase_q >= half) ? '0 : 23'(prod >>> 8);
					ov_q <= 1'b1;
				end
				aer_pkg::ST_DONE: begin
					ov_q <= 1'b1;
					case (sel_q)
						aer_pkg::FX_CRUSH: res_q <= 23'(y_c & $signed(cmask));
						aer_pkg::FX_DECIMATE: begin
							if (hcnt_q <= 6'd1) begin
								hcnt_q <= 6'(7'd1 + 7'(({5'd0, depth_q} * 17'd32) >> 12));
								held_q <= x_q;
								res_q <= 23'(x_q);
							end else begin
								hcnt_q <= hcnt_q - 6'd1;
								res_q <= 23'(held_q);
							end
						end
						aer_pkg::FX_MUTE: res_q <= '0;
						default: res_q <= 23'(x_q);
					endcase
				end
				default: ;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != aer_pkg::ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> (ov_q && $stable(res_q))) else $error("result lost");
	a_state_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(band_q <= 22'sd1048576) && (band_q >= -22'sd1048576)) else $error("band range");
endmodule
